// ===== hw/rtl/rar_pkg.sv =====
package rar_pkg;

	localparam int RES_NUM_W = 33;
	localparam int RES_DEN_W = 32;
	localparam int OUT_DATA_W = ((RES_NUM_W + RES_DEN_W + 7) / 8) * 8;
	localparam int MODE_W = 2;

	typedef enum logic [MODE_W-1:0] {
		MODE_ADD = 2'd0,
		MODE_SUB = 2'd1,
		MODE_MUL = 2'd2,
		MODE_DIV = 2'd3
	} mode_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_MUL,
		ST_SUM,
		ST_MAG,
		ST_EUC,
		ST_EUC_DIV,
		ST_RED_N,
		ST_RED_D,
		ST_FIN,
		ST_OUT
	} back_state_t;

	typedef struct packed {
		logic start;
		logic done;
	} div_ctrl_t;

endpackage

// ===== hw/rtl/rar_front.sv =====
module rar_front #(
	parameter int ITEM_W = 66
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic [ITEM_W-1:0] in_item,
	output logic              item_valid,
	input  logic              item_ready,
	output logic [ITEM_W-1:0] item
);
	logic [ITEM_W-1:0] mem_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;
	logic       push;
	logic       pop;

	assign in_ready   = (count_q != 2'd2);
	assign item_valid = (count_q != 2'd0);
	assign item       = mem_q[rd_ptr_q];
	assign push       = in_valid && in_ready;
	assign pop        = item_valid && item_ready;

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= in_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) wr_ptr_q <= ~wr_ptr_q;
			if (pop) rd_ptr_q <= ~rd_ptr_q;
			if (push && !pop) count_q <= count_q + 2'd1;
			else if (pop && !push) count_q <= count_q - 2'd1;
		end
	end
endmodule

// ===== hw/rtl/rar_divider.sv =====
module rar_divider #(
	parameter int RW = 33
) (
	input  logic          clk,
	input  logic          arst_n,
	input  rar_pkg::div_ctrl_t ctrl_in,
	output rar_pkg::div_ctrl_t ctrl_out,
	input  logic [RW-1:0] dividend,
	input  logic [RW-1:0] divisor,
	output logic [RW-1:0] quotient,
	output logic [RW-1:0] remainder
);
	import rar_pkg::*;
	localparam int CW = $clog2(RW + 1);

	logic [RW-1:0] quo_q;
	logic [RW-1:0] rem_q;
	logic [RW-1:0] dvs_q;
	logic [CW-1:0] cnt_q;
	logic          done_q;
	logic [RW:0]   shifted;
	logic [RW+1:0] diff;

	// One quotient bit per cycle, restoring form.
	assign shifted = {rem_q, quo_q[RW-1]};
	assign diff    = {1'b0, shifted} - {2'b00, dvs_q};

	always_ff @(posedge clk) begin
		if (ctrl_in.start) begin
			quo_q <= dividend;
			rem_q <= '0;
			dvs_q <= divisor;
		end else if (cnt_q != '0) begin
			if (!diff[RW+1]) begin
				rem_q <= diff[RW-1:0];
				quo_q <= {quo_q[RW-2:0], 1'b1};
			end else begin
				rem_q <= shifted[RW-1:0];
				quo_q <= {quo_q[RW-2:0], 1'b0};
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= (cnt_q == CW'(1)) && !ctrl_in.start;
			if (ctrl_in.start) cnt_q <= CW'(RW);
			else if (cnt_q != '0) cnt_q <= cnt_q - CW'(1);
		end
	end

	assign ctrl_out.start = 1'b0;
	assign ctrl_out.done  = done_q;
	assign quotient  = quo_q;
	assign remainder = rem_q;
endmodule

// ===== hw/rtl/rar_back.sv =====
module rar_back #(
	parameter int W = 16
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                item_valid,
	output logic                item_ready,
	input  logic [4*W+1:0]      item,
	output logic                m_tvalid,
	input  logic                m_tready,
	output logic [rar_pkg::RES_NUM_W-1:0] res_num,
	output logic [rar_pkg::RES_DEN_W-1:0] res_den,
	output logic                den_zero
);
	import rar_pkg::*;
	localparam int RW = (2 * W + 1 > 64) ? 64 : 2 * W + 1;

	back_state_t state_q, state_d;
	mode_t        mode_q;
	logic signed [W-1:0] na_q, da_q, nb_q, db_q;
	logic [1:0]   mstep_q;
	logic signed [W-1:0] mul_a, mul_b;
	logic signed [2*W-1:0] prod;
	logic [RW-1:0] p0_q, p1_q, p2_q;
	logic [RW-1:0] rn_q, rd_q;
	logic [RW-1:0] nm_q, dm_q, am_q, bm_q;
	logic          nneg_q, dneg_q, an_q, bn_q;
	div_ctrl_t     div_in, div_out;
	logic [RW-1:0] div_a, div_b, div_quo, div_rem;

	always_comb begin
		unique case (mstep_q)
			2'd0: begin
				mul_a = na_q;
				mul_b = (mode_q == MODE_MUL) ? nb_q : db_q;
			end
			2'd1: begin
				mul_a = da_q;
				mul_b = (mode_q == MODE_MUL) ? db_q : nb_q;
			end
			default: begin
				mul_a = da_q;
				mul_b = db_q;
			end
		endcase
	end
	assign prod = mul_a * mul_b;

	always_comb begin
		state_d      = state_q;
		div_in.start = 1'b0;
		div_in.done  = 1'b0;
		div_a        = nm_q;
		div_b        = am_q;
		unique case (state_q)
			ST_IDLE: if (item_valid) state_d = ST_MUL;
			ST_MUL: if (mstep_q == 2'd2) state_d = ST_SUM;
			ST_SUM: state_d = ST_MAG;
			ST_MAG: state_d = ST_EUC;
			ST_EUC: begin
				if (bm_q != '0) begin
					div_in.start = 1'b1;
					div_a = am_q;
					div_b = bm_q;
					state_d = ST_EUC_DIV;
				end else if (am_q != '0 && !an_q) begin
					div_in.start = 1'b1;
					state_d = ST_RED_N;
				end else begin
					state_d = ST_FIN;
				end
			end
			ST_EUC_DIV: if (div_out.done) state_d = ST_EUC;
			ST_RED_N: begin
				if (div_out.done) begin
					div_in.start = 1'b1;
					div_a = dm_q;
					state_d = ST_RED_D;
				end
			end
			ST_RED_D: if (div_out.done) state_d = ST_FIN;
			ST_FIN: state_d = ST_OUT;
			ST_OUT: if (m_tready) state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				mode_q  <= mode_t'(item[1:0]);
				na_q    <= item[W+1:2];
				da_q    <= item[2*W+1:W+2];
				nb_q    <= item[3*W+1:2*W+2];
				db_q    <= item[4*W+1:3*W+2];
				mstep_q <= 2'd0;
			end
			ST_MUL: begin
				if (mstep_q == 2'd0) p0_q <= RW'(prod);
				else if (mstep_q == 2'd1) p1_q <= RW'(prod);
				else p2_q <= RW'(prod);
				mstep_q <= mstep_q + 2'd1;
			end
			ST_SUM: begin
				unique case (mode_q)
					MODE_ADD: begin rn_q <= p0_q + p1_q; rd_q <= p2_q; end
					MODE_SUB: begin rn_q <= p0_q - p1_q; rd_q <= p2_q; end
					default:  begin rn_q <= p0_q; rd_q <= p1_q; end
				endcase
			end
			ST_MAG: begin
				nneg_q <= rn_q[RW-1];
				dneg_q <= rd_q[RW-1];
				an_q   <= rn_q[RW-1];
				bn_q   <= rd_q[RW-1];
				nm_q   <= rn_q[RW-1] ? -rn_q : rn_q;
				dm_q   <= rd_q[RW-1] ? -rd_q : rd_q;
				am_q   <= rn_q[RW-1] ? -rn_q : rn_q;
				bm_q   <= rd_q[RW-1] ? -rd_q : rd_q;
			end
			ST_EUC_DIV: begin
				// A remainder keeps the sign of its dividend.
				if (div_out.done) begin
					am_q <= bm_q;
					an_q <= bn_q;
					bm_q <= div_rem;
					bn_q <= an_q;
				end
			end
			ST_RED_N: if (div_out.done) nm_q <= div_quo;
			ST_RED_D: if (div_out.done) dm_q <= div_quo;
			ST_FIN: begin
				rn_q <= nneg_q ? -nm_q : nm_q;
				rd_q <= dneg_q ? -dm_q : dm_q;
			end
			default: begin
			end
		endcase
	end

	rar_divider #(.RW(RW)) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctrl_in  (div_in),
		.ctrl_out (div_out),
		.dividend (div_a),
		.divisor  (div_b),
		.quotient (div_quo),
		.remainder(div_rem)
	);

	assign item_ready = (state_q == ST_IDLE);
	assign m_tvalid   = (state_q == ST_OUT);
	assign res_num    = RES_NUM_W'($signed(rn_q));
	assign res_den    = RES_DEN_W'($signed(rd_q));
	assign den_zero   = (rd_q == '0);

	a_div_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		div_in.start |-> (div_b != '0))
		else $error("divider started with a zero divisor");
	a_euc_return: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_EUC_DIV && div_out.done) |=> (state_q == ST_EUC))
		else $error("remainder step did not return to the loop test");
	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tready) |=> (m_tvalid && $stable(rn_q) && $stable(rd_q)))
		else $error("pending result changed before it was taken");
endmodule

// ===== hw/rtl/rational_arith_reduce.sv =====
// Time per request grows with E, the number of Euclid remainder steps (up to about 46); each
// Euclid step and each of the up to two reducing divisions runs the serial divider to its end.
// Throughput: one request at a time in the back end, set by the shared serial divider
// that gives one quotient bit per cycle; a two-entry queue takes requests meanwhile.
// Reset: arst_n clears the queue and the sequencer asynchronously; data registers hold.
module rational_arith_reduce #(
	parameter int OPERAND_WIDTH = 16
) (
	input  logic clk,
	input  logic arst_n,
	input  logic s_tvalid,
	output logic s_tready,
	// num_a, den_a, num_b, den_b from the lowest bit up, zero padded
	input  logic [((4*OPERAND_WIDTH+7)/8)*8-1:0] s_tdata,
	// mode
	input  logic [rar_pkg::MODE_W-1:0] s_tuser,
	output logic m_tvalid,
	input  logic m_tready,
	// res_num, res_den from the lowest bit up, zero padded
	output logic [rar_pkg::OUT_DATA_W-1:0] m_tdata,
	// den_zero
	output logic m_tuser
);
	import rar_pkg::*;
	localparam int W = OPERAND_WIDTH;
	localparam int ITEM_W = 4 * W + MODE_W;

	logic              item_valid;
	logic              item_ready;
	logic [ITEM_W-1:0] item;
	logic [RES_NUM_W-1:0] res_num;
	logic [RES_DEN_W-1:0] res_den;

	rar_front #(.ITEM_W(ITEM_W)) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.in_item   ({s_tdata[4*W-1:0], s_tuser}),
		.item_valid(item_valid),
		.item_ready(item_ready),
		.item      (item)
	);

	rar_back #(.W(W)) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.item_valid(item_valid),
		.item_ready(item_ready),
		.item      (item),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.res_num   (res_num),
		.res_den   (res_den),
		.den_zero  (m_tuser)
	);

	assign m_tdata = {{(OUT_DATA_W - RES_NUM_W - RES_DEN_W){1'b0}}, res_den, res_num};
endmodule

// ===== test/rar_checker.sv =====
module rar_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	input  logic        s_tready,
	input  logic [63:0] s_tdata,
	input  logic [1:0]  s_tuser,
	input  logic        m_tvalid,
	input  logic        m_tready,
	input  logic [rar_pkg::OUT_DATA_W-1:0] m_tdata,
	input  logic        m_tuser,
	output int          fail_count,
	output int          pending,
	output int          results_seen
);
	import rar_pkg::*;

	typedef struct {
		logic [RES_NUM_W-1:0] num;
		logic [RES_DEN_W-1:0] den;
		logic                 zero;
	} fraction_t;

	fraction_t reduced_q[$];

	// Euclid on magnitudes; the gcd's sign follows the dividend that ends the chain.
	function automatic fraction_t reduce_fraction(mode_t op, logic [63:0] d);
		logic [63:0] na, da, nb, db, rn, rd, am, bm, rm, nm, dm;
		logic an, bn, rsgn, nneg, dneg;
		fraction_t r;
		na = 64'(signed'(d[15:0]));
		da = 64'(signed'(d[31:16]));
		nb = 64'(signed'(d[47:32]));
		db = 64'(signed'(d[63:48]));
		case (op)
			MODE_ADD: begin rn = na * db + nb * da; rd = da * db; end
			MODE_SUB: begin rn = na * db - nb * da; rd = da * db; end
			MODE_MUL: begin rn = na * nb; rd = da * db; end
			default:  begin rn = na * db; rd = da * nb; end
		endcase
		nneg = rn[63];
		dneg = rd[63];
		nm = nneg ? -rn : rn;
		dm = dneg ? -rd : rd;
		am = nm; an = nneg; bm = dm; bn = dneg;
		while (bm != 0) begin
			rm = am % bm;
			rsgn = an;
			am = bm; an = bn;
			bm = rm; bn = rsgn;
		end
		if (am != 0 && !an) begin
			nm = nm / am;
			dm = dm / am;
			rn = nneg ? -nm : nm;
			rd = dneg ? -dm : dm;
		end
		r.num = rn[RES_NUM_W-1:0];
		r.den = rd[RES_DEN_W-1:0];
		r.zero = (rd == 0);
		return r;
	endfunction

	assign pending = reduced_q.size();

	always @(posedge clk or negedge arst_n) begin
		fraction_t e;
		if (!arst_n) begin
			fail_count <= 0;
			results_seen <= 0;
		end else begin
			if (s_tvalid && s_tready)
				reduced_q.push_back(reduce_fraction(mode_t'(s_tuser), s_tdata));
			if (m_tvalid && m_tready) begin
				results_seen <= results_seen + 1;
				if (reduced_q.size() == 0) begin
					$error("result with no request pending");
					fail_count <= fail_count + 1;
				end else begin
					e = reduced_q.pop_front();
					if (m_tdata[RES_NUM_W-1:0] !== e.num ||
					    m_tdata[RES_NUM_W+RES_DEN_W-1:RES_NUM_W] !== e.den ||
					    m_tuser !== e.zero)
						fail_count <= fail_count + 1;
					if (m_tdata[RES_NUM_W-1:0] !== e.num)
						$error("res_num expected %h actual %h", e.num,
							m_tdata[RES_NUM_W-1:0]);
					if (m_tdata[RES_NUM_W+RES_DEN_W-1:RES_NUM_W] !== e.den)
						$error("res_den expected %h actual %h", e.den,
							m_tdata[RES_NUM_W+RES_DEN_W-1:RES_NUM_W]);
					if (m_tuser !== e.zero)
						$error("den_zero expected %b actual %b", e.zero, m_tuser);
				end
			end
		end
	end
endmodule

// ===== test/tb.sv =====
module tb;
	import rar_pkg::*;

	localparam int IDLE_LIMIT = 40000;

	logic clk = 0;
	logic arst_n = 0;
	logic s_tvalid = 0;
	logic s_tready;
	logic [63:0] s_tdata = '0;
	logic [1:0] s_tuser = '0;
	logic m_tvalid;
	logic m_tready = 0;
	logic [OUT_DATA_W-1:0] m_tdata;
	logic m_tuser;
	int fail_count, pending, results_seen;
	int send_idle_pct = 0, recv_stall_pct = 0;
	int quiet_cycles = 0;

	always #1 clk = ~clk;

	rational_arith_reduce i_dut (.*);

	rar_checker i_chk (.*);

	always @(negedge clk)
		m_tready <= ($urandom_range(99) >= recv_stall_pct);

	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles > IDLE_LIMIT) begin
			$display("Some tests failed");
			$finish;
		end
	end

	// Leaves s_tvalid high after the accepting edge; the caller drops it when the
	// sender goes quiet.
	task automatic send_request(mode_t op, logic [15:0] na, logic [15:0] da,
			logic [15:0] nb, logic [15:0] db);
		while ($urandom_range(99) < send_idle_pct) begin
			s_tvalid <= 0;
			@(negedge clk);
		end
		s_tvalid <= 1;
		s_tuser <= op;
		s_tdata <= {db, nb, da, na};
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		@(negedge clk);
	endtask

	// Small magnitudes half the time so Euclid stays short; full-range and extreme values otherwise.
	function automatic logic [15:0] pick_operand();
		case ($urandom_range(3))
			0: return 16'($urandom);
			1: return 16'($signed($urandom_range(40)) - 20);
			2: return $urandom_range(1) ? 16'h8000 : 16'h7fff;
			default: return 16'($signed($urandom_range(600)) - 300);
		endcase
	endfunction

	initial begin
		mode_t op;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1;
		for (int m = 0; m < 4; m++) begin
			op = mode_t'(m);
			send_request(op, 16'h7fff, 16'h8000, 16'h8000, 16'h7fff);
			send_request(op, 16'hfffe, 16'd4, 16'd1, 16'd3);
			send_request(op, 16'd0, 16'd0, 16'd0, 16'd0);
			send_request(op, 16'd5, 16'd0, 16'hfffd, 16'd7);
			send_request(op, 16'hffff, 16'hffff, 16'h0000, 16'hffff);
		end
		s_tvalid <= 0;
		// Hold until every outstanding request has returned.
		while (pending != 0) @(negedge clk);
		for (int ph = 0; ph < 4; ph++) begin
			send_idle_pct = (ph == 1 || ph == 3) ? ((ph == 1) ? 46 : 32) : 0;
			recv_stall_pct = (ph == 2 || ph == 3) ? ((ph == 2) ? 46 : 32) : 0;
			for (int i = 0; i < 88; i++)
				send_request(mode_t'($urandom_range(3)), pick_operand(), pick_operand(),
					pick_operand(), pick_operand());
		end
		s_tvalid <= 0;
		while (pending != 0) @(negedge clk);
		repeat (50) @(negedge clk);
		$display("Covered all four operations with extreme, zero and random operands;");
		$display("%0d results checked under varied idle and stall rates.", results_seen);
		if (fail_count == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end
endmodule
